// ===== design/assert_macros.svh =====
// ------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertions with asynchronous reset disable.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== design/cs4d_pkg.sv =====
// ------------------------------------------------------------------------
// cs4d_pkg
// Request and result types of the cosine similarity block.
// ------------------------------------------------------------------------
package cs4d_pkg;

	localparam int FIELD_W = 32;
	localparam int Q_W     = 17;
	localparam int FRAC_W  = 16;

	typedef struct packed {
		logic [FIELD_W-1:0] a_elem0;
		logic [FIELD_W-1:0] a_elem1;
		logic [FIELD_W-1:0] a_elem2;
		logic [FIELD_W-1:0] a_elem3;
		logic [FIELD_W-1:0] b_elem0;
		logic [FIELD_W-1:0] b_elem1;
		logic [FIELD_W-1:0] b_elem2;
		logic [FIELD_W-1:0] b_elem3;
	} req_t;

	typedef struct packed {
		logic [Q_W-1:0] similarity;
		logic           zero_norm;
	} res_t;

endpackage

// ===== design/cosine_similarity_4d.sv =====
// ------------------------------------------------------------------------
// cosine_similarity_4d
// Exact Q1.16 cosine similarity of two unsigned vectors.
// ------------------------------------------------------------------------
// Throughput: one request per cycle while no full queue stalls the pipe;
// set by the 17-stage bit search, one result bit per stage, all stages
// moving together.
// Reset: arst_n clears all valid bits and queue counts; payload is unreset.
// ------------------------------------------------------------------------
module cosine_similarity_4d
	import cs4d_pkg::*;
#(
	parameter int VECTOR_LEN = 4,
	parameter int ELEM_BITS  = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  req_t req,
	output logic full,
	output logic empty,
	input  logic pop,
	output res_t res
);
	// exact sum width: squares of ELEM_BITS plus two carry bits
	localparam int SUM_W = 2*ELEM_BITS+2;
	localparam int QW    = 3*SUM_W;

	logic          q_push, q_full, q_pop, q_empty;
	logic [QW-1:0] q_din, q_dout;
	logic          o_push, o_full;
	res_t          o_din;

	// front: products and sums of each request
	cs4d_front #(
		.VECTOR_LEN(VECTOR_LEN),
		.ELEM_BITS (ELEM_BITS),
		.SUM_W     (SUM_W)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.req   (req),
		.full  (full),
		.q_push(q_push),
		.q_din (q_din),
		.q_full(q_full)
	);

	// decoupling queue between front and back
	cs4d_fifo #(.W(QW)) u_mid_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (q_din),
		.full  (q_full),
		.pop   (q_pop),
		.dout  (q_dout),
		.empty (q_empty)
	);

	// back: wide products and the quotient search
	cs4d_back #(.SUM_W(SUM_W)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(q_empty),
		.q_dout (q_dout),
		.q_pop  (q_pop),
		.o_push (o_push),
		.o_din  (o_din),
		.o_full (o_full)
	);

	// result queue: results wait here while the consumer stalls
	cs4d_fifo #(.W($bits(res_t))) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (o_push),
		.din   (o_din),
		.full  (o_full),
		.pop   (pop),
		.dout  (res),
		.empty (empty)
	);
endmodule

// ===== design/cs4d_fifo.sv =====
// ------------------------------------------------------------------------
// cs4d_fifo
// Two-entry queue, push/full and pop/empty.
// ------------------------------------------------------------------------
module cs4d_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);
	logic [W-1:0] mem [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   cnt_q;
	logic         do_push;
	logic         do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem[wr_ptr_q] <= din;
	end
endmodule

// ===== design/cs4d_front.sv =====
// ------------------------------------------------------------------------
// cs4d_front
// Takes requests, forms element products and the three exact sums.
// ------------------------------------------------------------------------
module cs4d_front
	import cs4d_pkg::*;
#(
	parameter int VECTOR_LEN = 4,
	parameter int ELEM_BITS  = 32,
	parameter int SUM_W      = 2*ELEM_BITS+2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  req_t               req,
	output logic               full,
	output logic               q_push,
	output logic [3*SUM_W-1:0] q_din,
	input  logic               q_full
);
	localparam int PR_W = 2*ELEM_BITS;

	logic [FIELD_W-1:0] av [4];
	logic [FIELD_W-1:0] bv [4];
	logic [PR_W-1:0] ab_s1 [VECTOR_LEN];
	logic [PR_W-1:0] aa_s1 [VECTOR_LEN];
	logic [PR_W-1:0] bb_s1 [VECTOR_LEN];
	logic            v_s1;
	logic [SUM_W-1:0] d_s2, na_s2, nb_s2;
	logic [SUM_W-1:0] d_sum, na_sum, nb_sum;
	logic            v_s2;
	logic            en;

	assign av[0] = req.a_elem0;
	assign av[1] = req.a_elem1;
	assign av[2] = req.a_elem2;
	assign av[3] = req.a_elem3;
	assign bv[0] = req.b_elem0;
	assign bv[1] = req.b_elem1;
	assign bv[2] = req.b_elem2;
	assign bv[3] = req.b_elem3;

	// stage advances unless the sums are stuck on a full queue
	assign en     = !v_s2 || !q_full;
	assign full   = !en;
	assign q_push = v_s2;
	assign q_din  = {d_s2, na_s2, nb_s2};

	always_comb begin
		d_sum  = '0;
		na_sum = '0;
		nb_sum = '0;
		for (int i = 0; i < VECTOR_LEN; i++) begin
			d_sum  = d_sum  + SUM_W'(ab_s1[i]);
			na_sum = na_sum + SUM_W'(aa_s1[i]);
			nb_sum = nb_sum + SUM_W'(bb_s1[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= push;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < VECTOR_LEN; i++) begin
				ab_s1[i] <= av[i][ELEM_BITS-1:0] * bv[i][ELEM_BITS-1:0];
				aa_s1[i] <= av[i][ELEM_BITS-1:0] * av[i][ELEM_BITS-1:0];
				bb_s1[i] <= bv[i][ELEM_BITS-1:0] * bv[i][ELEM_BITS-1:0];
			end
			d_s2  <= d_sum;
			na_s2 <= na_sum;
			nb_s2 <= nb_sum;
		end
	end
endmodule

// ===== design/cs4d_back.sv =====
// ------------------------------------------------------------------------
// cs4d_back
// Norm product, squared dot product, and a bit-per-stage search for the
// largest q with q^2*NA*NB <= 2^32*D^2.
// ------------------------------------------------------------------------
module cs4d_back
	import cs4d_pkg::*;
#(
	parameter int SUM_W = 66
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  logic [3*SUM_W-1:0] q_dout,
	output logic               q_pop,
	output logic               o_push,
	output res_t               o_din,
	input  logic               o_full
);
	localparam int H   = SUM_W/2;
	localparam int HH  = SUM_W-H;
	localparam int HW  = H+HH;
	localparam int PW  = 2*SUM_W;
	localparam int RW  = PW+2*FRAC_W;
	localparam int TW  = PW+2*Q_W+1;
	localparam int UW  = PW+Q_W;
	localparam int NST = Q_W;

	logic [SUM_W-1:0] d_in, na_in, nb_in;
	logic en;

	logic [2*H-1:0]  pp0_s1, rr0_s1;
	logic [H+HH-1:0] pp1_s1, pp2_s1, rr1_s1, rr2_s1;
	logic [2*HH-1:0] pp3_s1, rr3_s1;
	logic            zn_s1, v_s1;

	logic [TW-1:0]  t_sn [NST+1];
	logic [UW-1:0]  u_sn [NST+1];
	logic [Q_W-1:0] qv_sn [NST+1];
	logic [PW-1:0]  p_sn [NST+1];
	logic [RW-1:0]  r_sn [NST+1];
	logic           zn_sn [NST+1];
	logic           v_sn [NST+1];

	assign {d_in, na_in, nb_in} = q_dout;

	assign en     = !v_sn[NST] || !o_full;
	assign q_pop  = en && !q_empty;
	assign o_push = v_sn[NST];
	assign o_din.similarity = zn_sn[NST] ? '0 : qv_sn[NST];
	assign o_din.zero_norm  = zn_sn[NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int j = 0; j <= NST; j++) v_sn[j] <= 1'b0;
		end else if (en) begin
			v_s1    <= !q_empty;
			v_sn[0] <= v_s1;
			for (int j = 0; j < NST; j++) v_sn[j+1] <= v_sn[j];
		end
	end

	// partial products of the two wide multiplies
	always_ff @(posedge clk) begin
		if (en) begin
			pp0_s1 <= na_in[H-1:0] * nb_in[H-1:0];
			pp1_s1 <= HW'(na_in[H-1:0]) * HW'(nb_in[SUM_W-1:H]);
			pp2_s1 <= HW'(na_in[SUM_W-1:H]) * HW'(nb_in[H-1:0]);
			pp3_s1 <= na_in[SUM_W-1:H] * nb_in[SUM_W-1:H];
			rr0_s1 <= d_in[H-1:0] * d_in[H-1:0];
			rr1_s1 <= HW'(d_in[H-1:0]) * HW'(d_in[SUM_W-1:H]);
			rr2_s1 <= HW'(d_in[SUM_W-1:H]) * HW'(d_in[H-1:0]);
			rr3_s1 <= d_in[SUM_W-1:H] * d_in[SUM_W-1:H];
			zn_s1  <= (na_in == '0) || (nb_in == '0);
		end
	end

	// recombine: P = NA*NB, R = D^2 << 32
	always_ff @(posedge clk) begin
		if (en) begin
			p_sn[0]  <= PW'(pp0_s1) + (PW'(pp1_s1) << H) + (PW'(pp2_s1) << H)
				+ (PW'(pp3_s1) << (2*H));
			r_sn[0]  <= RW'(PW'(rr0_s1) + (PW'(rr1_s1) << H) + (PW'(rr2_s1) << H)
				+ (PW'(rr3_s1) << (2*H))) << (2*FRAC_W);
			t_sn[0]  <= '0;
			u_sn[0]  <= '0;
			qv_sn[0] <= '0;
			zn_sn[0] <= zn_s1;
		end
	end

	// one result bit per stage; T tracks q^2*P and U tracks q*P
	for (genvar j = 0; j < NST; j++) begin : g_bit
		localparam int K = NST-1-j;
		logic [TW-1:0] cand;
		logic          take;

		assign cand = t_sn[j] + (TW'(u_sn[j]) << (K+1)) + (TW'(p_sn[j]) << (2*K));
		// once q reaches 1.0 no lower bit may be added
		assign take = !qv_sn[j][Q_W-1] && (cand <= TW'(r_sn[j]));

		always_ff @(posedge clk) begin
			if (en) begin
				t_sn[j+1]  <= take ? cand : t_sn[j];
				u_sn[j+1]  <= take ? u_sn[j] + (UW'(p_sn[j]) << K) : u_sn[j];
				qv_sn[j+1] <= take ? (qv_sn[j] | (Q_W'(1) << K)) : qv_sn[j];
				p_sn[j+1]  <= p_sn[j];
				r_sn[j+1]  <= r_sn[j];
				zn_sn[j+1] <= zn_sn[j];
			end
		end
	end
endmodule

// ===== design/cs4d_checker.sv =====
// ------------------------------------------------------------------------
// cs4d_checker
// Port-level checks on the cosine similarity block.
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module cs4d_checker
	import cs4d_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input logic empty,
	input logic pop,
	input res_t res
);
	`ASSERT_IMPL(a_zero_clears, clk, arst_n, !empty && res.zero_norm, res.similarity == '0)
	`ASSERT_IMPL(a_in_range, clk, arst_n, !empty, res.similarity <= Q_W'(1 << FRAC_W))
	`ASSERT_NEXT(a_res_hold, clk, arst_n, !empty && !pop, !empty && $stable(res))
	`ASSERT_NEXT(a_no_early, clk, arst_n, empty && !push, empty || !full)
endmodule

bind cosine_similarity_4d cs4d_checker u_chk (
	.clk   (clk),
	.arst_n(arst_n),
	.push  (push),
	.full  (full),
	.empty (empty),
	.pop   (pop),
	.res   (res)
);
